### rtl/assert_macros.svh
// Assertion macros for the stereo doubler RTL, included by the top level.
// Depends on nothing; the using module must have i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SDW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sdw_pkg.sv
// Package for the stereo doubler: widths, constants, register indexes,
// controller states and the structs passed between modules. No dependencies.
package sdw_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int AMT_W      = 13;
    localparam int WID_W      = 14;
    localparam int DLY_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int G_W        = 11;
    localparam int DRY_W      = 13;
    localparam int SIDE_W     = 27;
    localparam int MID_W      = 28;
    localparam int PA_W       = 38;
    localparam int ACC_W      = 40;

    localparam int DELAY_DEPTH_DEF = 8192;

    localparam logic [AMT_W-1:0] GAIN_ONE     = AMT_W'(4096);
    localparam logic [AMT_W-1:0] BYPASS_LIMIT = AMT_W'(40);
    localparam logic [WID_W-1:0] WID_MAX      = WID_W'(8192);
    localparam int               WET_SCALE    = 1638;

    localparam logic [AMT_W-1:0] AMOUNT_RST  = AMT_W'(0);
    localparam logic [WID_W-1:0] WIDTH_RST   = WID_W'(4096);
    localparam logic [DLY_W-1:0] DLY_L_RST   = DLY_W'(485);
    localparam logic [DLY_W-1:0] DLY_R_RST   = DLY_W'(749);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AMOUNT = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_DLY_L  = 2'd2,
        CFG_DLY_R  = 2'd3
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE, S_TAPL, S_TAPR, S_SIDE, S_WETL, S_DRYR, S_WETR, S_DONE
    } t_state;

    // Step strobes from the sequencer.
    typedef struct packed {
        logic accept;
        logic wr_mono;
        logic rd_r;
        logic side;
        logic wet_l;
        logic dry_r;
        logic wet_r;
        logic push;
    } t_ctrl;

    // Status of the address unit.
    typedef struct packed {
        logic busy;
        logic clearing;
        logic fwd_l;
    } t_addr_st;

endpackage

### rtl/sdw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sdw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read; a read of the address being written returns old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sdw_addr.sv
// Address unit: write pointer, clearing pass, delay registers and tap addresses.
// Depends on sdw_pkg.
module sdw_addr #(
    parameter int DELAY_DEPTH = sdw_pkg::DELAY_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sdw_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sdw_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  sdw_pkg::t_ctrl                      i_ctrl,
    input  logic signed [sdw_pkg::SAMPLE_W-1:0] i_mono,
    output logic                                o_ram_we,
    output logic [$clog2(DELAY_DEPTH)-1:0]      o_ram_waddr,
    output logic [sdw_pkg::SAMPLE_W-1:0]        o_ram_wdata,
    output logic [$clog2(DELAY_DEPTH)-1:0]      o_ram_raddr,
    output sdw_pkg::t_addr_st                   o_st
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam logic [16:0]   DEPTH_X = 17'(DELAY_DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(DELAY_DEPTH - 1);

    logic [AW-1:0]                r_wp;
    logic [AW-1:0]                r_clr_addr;
    logic                         r_clearing;
    logic [sdw_pkg::DLY_W-1:0]    r_dl;
    logic [sdw_pkg::DLY_W-1:0]    r_dr;
    logic                         dl_big;
    logic                         dr_big;
    logic [AW-1:0]                tap_l;
    logic [AW-1:0]                tap_r;
    sdw_pkg::t_cfg_idx            cfg_idx;

    // Position a given delay behind the write pointer, wrapping at the depth.
    function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] wp,
                                               input logic [sdw_pkg::DLY_W-1:0] dly);
        logic [AW:0] diff;
        logic [AW:0] wrapped;
        diff    = {1'b0, wp} - {1'b0, AW'(dly)};
        wrapped = diff + (AW+1)'(DELAY_DEPTH);
        return diff[AW] ? wrapped[AW-1:0] : diff[AW-1:0];
    endfunction

    assign cfg_idx = sdw_pkg::t_cfg_idx'(i_cfg_idx);
    assign dl_big  = {4'b0, r_dl} >= DEPTH_X;
    assign dr_big  = {4'b0, r_dr} >= DEPTH_X;
    assign tap_l   = tap_addr(r_wp, r_dl);
    assign tap_r   = tap_addr(r_wp, r_dr);

    // Delay registers reduce themselves below the depth, one subtraction per cycle unless written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl <= sdw_pkg::DLY_L_RST;
            r_dr <= sdw_pkg::DLY_R_RST;
        end else begin
            if (i_cfg_we && cfg_idx == sdw_pkg::CFG_DLY_L) begin
                r_dl <= i_cfg_data[sdw_pkg::DLY_W-1:0];
            end else if (dl_big) begin
                r_dl <= r_dl - sdw_pkg::DLY_W'(DELAY_DEPTH);
            end
            if (i_cfg_we && cfg_idx == sdw_pkg::CFG_DLY_R) begin
                r_dr <= i_cfg_data[sdw_pkg::DLY_W-1:0];
            end else if (dr_big) begin
                r_dr <= r_dr - sdw_pkg::DLY_W'(DELAY_DEPTH);
            end
        end
    end

    // Clearing pass after reset, then the write pointer advances once per word that is not bypassed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_clr_addr <= '0;
            r_clearing <= 1'b1;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= (r_clr_addr == LAST) ? '0 : r_clr_addr + AW'(1);
                r_clearing <= (r_clr_addr != LAST);
            end
            if (i_ctrl.rd_r) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + AW'(1);
            end
        end
    end

    // Memory port selection.
    assign o_ram_we    = r_clearing || i_ctrl.wr_mono;
    assign o_ram_waddr = r_clearing ? r_clr_addr : r_wp;
    assign o_ram_wdata = r_clearing ? '0 : i_mono;
    assign o_ram_raddr = i_ctrl.rd_r ? tap_r : tap_l;

    // A zero left delay reads the entry written in the same cycle, so it is forwarded.
    assign o_st.busy     = r_clearing || dl_big || dr_big;
    assign o_st.clearing = r_clearing;
    assign o_st.fwd_l    = (r_dl == '0);

endmodule

### rtl/sdw_dp.sv
// Datapath: gain registers, mono mix, side signal and the dry/wet mix with saturation.
// Depends on sdw_pkg.
module sdw_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sdw_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sdw_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  sdw_pkg::t_ctrl                      i_ctrl,
    input  logic                                i_fwd_l,
    input  logic signed [sdw_pkg::SAMPLE_W-1:0] i_left_in,
    input  logic signed [sdw_pkg::SAMPLE_W-1:0] i_right_in,
    input  logic signed [sdw_pkg::SAMPLE_W-1:0] i_rdata,
    output logic signed [sdw_pkg::SAMPLE_W-1:0] o_mono,
    output logic                                o_bypass,
    output logic signed [sdw_pkg::SAMPLE_W-1:0] o_left_out,
    output logic signed [sdw_pkg::SAMPLE_W-1:0] o_right_out
);

    localparam int SW = sdw_pkg::SAMPLE_W;

    logic [sdw_pkg::AMT_W-1:0]        r_amount;
    logic [sdw_pkg::WID_W-1:0]        r_width;
    logic signed [SW-1:0]             r_in_l;
    logic signed [SW-1:0]             r_in_r;
    logic signed [SW-1:0]             r_mono;
    logic signed [SW-1:0]             r_tl;
    logic [sdw_pkg::G_W-1:0]          r_g;
    logic [sdw_pkg::DRY_W-1:0]        r_dry;
    logic [sdw_pkg::WID_W-1:0]        r_wid;
    logic                             r_byp;
    logic signed [sdw_pkg::SIDE_W-1:0] r_side;
    logic signed [sdw_pkg::PA_W-1:0]  r_pa;
    logic signed [sdw_pkg::ACC_W-1:0] r_acc;
    logic signed [SW-1:0]             r_ol;
    logic signed [SW-1:0]             r_out_l;
    logic signed [SW-1:0]             r_out_r;

    logic [sdw_pkg::AMT_W-1:0]        amt_c;
    logic [23:0]                      g_prod;
    logic [sdw_pkg::WID_W-1:0]        wid_c;
    logic signed [SW:0]               pair_sum;
    logic signed [SW:0]               tap_diff;
    logic signed [39:0]               side_prod;
    logic signed [sdw_pkg::MID_W-1:0] mid_p;
    logic signed [sdw_pkg::MID_W-1:0] mid_m;
    logic signed [sdw_pkg::MID_W-1:0] wet_in;
    logic signed [sdw_pkg::ACC_W-1:0] wet_prod;
    logic signed [SW-1:0]             dry_in;
    logic signed [sdw_pkg::PA_W-1:0]  dry_prod;
    logic signed [SW-1:0]             sat_acc;
    sdw_pkg::t_cfg_idx                cfg_idx;

    // Drop the Q12 fraction (floor) and clamp to the 24-bit range.
    function automatic logic signed [SW-1:0] sat24(input logic signed [sdw_pkg::ACC_W-1:0] acc);
        logic signed [sdw_pkg::ACC_W-13:0] sh;
        sh = acc[sdw_pkg::ACC_W-1:12];
        if (sh > (sdw_pkg::ACC_W-12)'(signed'(24'sh7FFFFF))) begin
            return 24'sh7FFFFF;
        end else if (sh < (sdw_pkg::ACC_W-12)'(signed'(24'sh800000))) begin
            return 24'sh800000;
        end
        return sh[SW-1:0];
    endfunction

    assign cfg_idx = sdw_pkg::t_cfg_idx'(i_cfg_idx);

    // Gain and width configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amount <= sdw_pkg::AMOUNT_RST;
            r_width  <= sdw_pkg::WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (cfg_idx)
                sdw_pkg::CFG_AMOUNT: r_amount <= i_cfg_data[sdw_pkg::AMT_W-1:0];
                sdw_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                sdw_pkg::CFG_DLY_L,
                sdw_pkg::CFG_DLY_R:  ;
            endcase
        end
    end

    // Clamp the registers and derive the wet gain g = (1638 * amount) >> 12.
    assign o_bypass = (r_amount <= sdw_pkg::BYPASS_LIMIT);
    assign amt_c    = (r_amount > sdw_pkg::GAIN_ONE) ? sdw_pkg::GAIN_ONE : r_amount;
    assign g_prod   = 24'(amt_c) * 24'(sdw_pkg::WET_SCALE);
    assign wid_c    = (r_width > sdw_pkg::WID_MAX) ? sdw_pkg::WID_MAX : r_width;
    assign pair_sum = (SW+1)'(i_left_in) + (SW+1)'(i_right_in);

    // Shared arithmetic: side product, dry product and wet product.
    assign tap_diff  = (SW+1)'(r_tl) - (SW+1)'(i_rdata);
    assign side_prod = tap_diff * $signed({1'b0, r_wid});
    assign mid_p     = sdw_pkg::MID_W'(r_mono) + sdw_pkg::MID_W'(r_side);
    assign mid_m     = sdw_pkg::MID_W'(r_mono) - sdw_pkg::MID_W'(r_side);
    assign wet_in    = i_ctrl.wet_l ? mid_p : mid_m;
    assign wet_prod  = wet_in * $signed({1'b0, r_g});
    assign dry_in    = i_ctrl.wr_mono ? r_in_l : r_in_r;
    assign dry_prod  = dry_in * $signed({1'b0, r_dry});
    assign sat_acc   = sat24(r_acc);

    // Step registers, loaded by the sequencer strobes; r_pa and r_acc are each loaded in two steps.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_in_l <= i_left_in;
            r_in_r <= i_right_in;
            r_mono <= pair_sum[SW:1];
            r_g    <= g_prod[22:12];
            r_dry  <= sdw_pkg::GAIN_ONE - sdw_pkg::DRY_W'(g_prod[22:12]);
            r_wid  <= wid_c;
            r_byp  <= o_bypass;
        end
        if (i_ctrl.wr_mono || i_ctrl.dry_r) begin
            r_pa <= dry_prod;
        end
        if (i_ctrl.rd_r) begin
            r_tl <= i_fwd_l ? r_mono : i_rdata;
        end
        if (i_ctrl.side) begin
            r_side <= side_prod[38:12];
        end
        if (i_ctrl.wet_l || i_ctrl.wet_r) begin
            r_acc <= sdw_pkg::ACC_W'(r_pa) + wet_prod;
        end
        if (i_ctrl.dry_r) begin
            r_ol <= sat_acc;
        end
        if (i_ctrl.push) begin
            r_out_l <= r_byp ? r_in_l : r_ol;
            r_out_r <= r_byp ? r_in_r : sat_acc;
        end
    end

    assign o_mono      = r_mono;
    assign o_left_out  = r_out_l;
    assign o_right_out = r_out_r;

endmodule

### rtl/stereo_doubler_delay_width_top.sv
// Stereo doubler top level: sequencer, output register and unit wiring.
// An accepted word runs through TAPL, TAPR, SIDE, WETL, DRYR, WETR and DONE before its output
// word is registered, and DONE waits until the output register is free; a bypassed word goes from
// IDLE straight to DONE. A new word is accepted only in IDLE, so words do not overlap, and both
// delay taps are read through the single RAM read port. Reset: synchronous active-low; a clearing
// pass then zeroes the whole delay memory, and no word is accepted until it ends.
`include "assert_macros.svh"

module stereo_doubler_delay_width_top #(
    parameter int DELAY_DEPTH = sdw_pkg::DELAY_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sdw_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sdw_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [sdw_pkg::SAMPLE_W-1:0] i_left_in,
    input  logic signed [sdw_pkg::SAMPLE_W-1:0] i_right_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [sdw_pkg::SAMPLE_W-1:0] o_left_out,
    output logic signed [sdw_pkg::SAMPLE_W-1:0] o_right_out
);

    localparam int AW = $clog2(DELAY_DEPTH);

    sdw_pkg::t_state                    r_state;
    sdw_pkg::t_state                    n_state;
    logic                               r_out_valid;
    logic                               n_out_valid;
    sdw_pkg::t_ctrl                     ctrl;
    sdw_pkg::t_addr_st                  addr_st;
    logic                               bypass;
    logic signed [sdw_pkg::SAMPLE_W-1:0] mono;
    logic                               ram_we;
    logic [AW-1:0]                      ram_waddr;
    logic [sdw_pkg::SAMPLE_W-1:0]       ram_wdata;
    logic [AW-1:0]                      ram_raddr;
    logic [sdw_pkg::SAMPLE_W-1:0]       ram_rdata;
    logic                               out_free;

    assign o_in_ready = (r_state == sdw_pkg::S_IDLE) && !addr_st.busy;
    assign out_free   = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sdw_pkg::S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_state = bypass ? sdw_pkg::S_DONE : sdw_pkg::S_TAPL;
                end
            end
            sdw_pkg::S_TAPL: n_state = sdw_pkg::S_TAPR;
            sdw_pkg::S_TAPR: n_state = sdw_pkg::S_SIDE;
            sdw_pkg::S_SIDE: n_state = sdw_pkg::S_WETL;
            sdw_pkg::S_WETL: n_state = sdw_pkg::S_DRYR;
            sdw_pkg::S_DRYR: n_state = sdw_pkg::S_WETR;
            sdw_pkg::S_WETR: n_state = sdw_pkg::S_DONE;
            sdw_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = sdw_pkg::S_IDLE;
                end
            end
        endcase
    end

    // Step strobes.
    always_comb begin
        ctrl = '0;
        unique case (r_state)
            sdw_pkg::S_IDLE: ctrl.accept  = i_in_valid && o_in_ready;
            sdw_pkg::S_TAPL: ctrl.wr_mono = 1'b1;
            sdw_pkg::S_TAPR: ctrl.rd_r    = 1'b1;
            sdw_pkg::S_SIDE: ctrl.side    = 1'b1;
            sdw_pkg::S_WETL: ctrl.wet_l   = 1'b1;
            sdw_pkg::S_DRYR: ctrl.dry_r   = 1'b1;
            sdw_pkg::S_WETR: ctrl.wet_r   = 1'b1;
            sdw_pkg::S_DONE: ctrl.push    = out_free;
        endcase
    end

    // Output word register: loaded on push, emptied when taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (ctrl.push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdw_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    sdw_addr #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_addr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_ctrl      (ctrl),
        .i_mono      (mono),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .o_st        (addr_st)
    );

    sdw_ram #(
        .WIDTH (sdw_pkg::SAMPLE_W),
        .DEPTH (DELAY_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sdw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_ctrl      (ctrl),
        .i_fwd_l     (addr_st.fwd_l),
        .i_left_in   (i_left_in),
        .i_right_in  (i_right_in),
        .i_rdata     ($signed(ram_rdata)),
        .o_mono      (mono),
        .o_bypass    (bypass),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out)
    );

    // The delay memory is written only by the clearing pass or the mono write step.
    `SDW_ASSERT_IMP(a_ram_wr_window, ram_we, (r_state == sdw_pkg::S_TAPL) || addr_st.clearing, "unexpected delay memory write")
    // While the memory is being cleared nothing is in flight or waiting at the output.
    `SDW_ASSERT_IMP(a_clear_quiet, addr_st.clearing, (r_state == sdw_pkg::S_IDLE) && !r_out_valid, "activity during clearing pass")
    // A new output word only appears after the final sequencer step.
    `SDW_ASSERT_IMP(a_valid_from_done, $rose(o_out_valid), $past(r_state) == sdw_pkg::S_DONE, "output valid outside final step")
    // An accepted input word always starts the sequence.
    `SDW_ASSERT_NXT(a_accept_starts, i_in_valid && o_in_ready, r_state != sdw_pkg::S_IDLE, "accepted word did not start processing")

endmodule

### tb/sv/stereo_doubler_delay_width_top_tb.sv
// Self-checking testbench for the stereo doubler with delay taps and side width.
// Depends on sdw_pkg and stereo_doubler_delay_width_top; predicts every output word
// from its own copy of the delay line and registers, and compares it in order.
module stereo_doubler_delay_width_top_tb;
    import sdw_pkg::*;

    localparam int DEPTH          = DELAY_DEPTH_DEF;
    localparam int IDLE_PCT       = 37;
    localparam int TIMEOUT_CYCLES = 400000;

    localparam logic signed [SAMPLE_W-1:0] PEAK_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] PEAK_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } t_stereo;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_idx;
    logic [CFG_DATA_W-1:0]       i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic signed [SAMPLE_W-1:0]  i_left_in;
    logic signed [SAMPLE_W-1:0]  i_right_in;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic signed [SAMPLE_W-1:0]  o_left_out;
    logic signed [SAMPLE_W-1:0]  o_right_out;

    // Expected output words, oldest first.
    t_stereo pending_mix[$];
    int      n_fail     = 0;
    bit      steady     = 1'b0;
    int      stall_left = 0;

    // Predictor state: mono delay line, write position and register copies.
    logic signed [SAMPLE_W-1:0] mono_line [DEPTH];
    int                         head;
    logic [AMT_W-1:0]           amount_q;
    logic [WID_W-1:0]           width_q;
    logic [DLY_W-1:0]           dly_l_q;
    logic [DLY_W-1:0]           dly_r_q;

    stereo_doubler_delay_width_top #(
        .DELAY_DEPTH (DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_left_in   (i_left_in),
        .i_right_in  (i_right_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run, well above the slowest legal completion.
    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("stereo_doubler_delay_width_top: mismatch");
        $finish;
    end

    function automatic logic signed [SAMPLE_W-1:0] clip24(input longint v);
        if (v > longint'(PEAK_POS)) return PEAK_POS;
        if (v < longint'(PEAK_NEG)) return PEAK_NEG;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic int tap_addr(input logic [DLY_W-1:0] d);
        return (head + DEPTH - (int'(d) % DEPTH)) % DEPTH;
    endfunction

    // Wet/dry mix of one stereo word; updates the delay line unless bypassed.
    function automatic t_stereo mix_model(input t_stereo dry_in);
        longint  l, r, amt, wid, m, tl, tr, side, g, dry;
        t_stereo res;
        l   = longint'(dry_in.left);
        r   = longint'(dry_in.right);
        amt = (amount_q > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(amount_q);
        wid = (width_q > WID_MAX) ? longint'(WID_MAX) : longint'(width_q);
        if (amt <= longint'(BYPASS_LIMIT)) return dry_in;
        m = (l + r) >>> 1;
        mono_line[head] = m[SAMPLE_W-1:0];
        tl   = longint'(mono_line[tap_addr(dly_l_q)]);
        tr   = longint'(mono_line[tap_addr(dly_r_q)]);
        side = ((tl - tr) * wid) >>> 12;
        g    = (WET_SCALE * amt) >>> 12;
        dry  = longint'(GAIN_ONE) - g;
        res.left  = clip24((l * dry + (m + side) * g) >>> 12);
        res.right = clip24((r * dry + (m - side) * g) >>> 12);
        head = (head + 1) % DEPTH;
        return res;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0: return PEAK_POS;
            1: return PEAK_NEG;
            2: return SAMPLE_W'($signed($urandom_range(512)) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offer one stereo word, with random gaps, and predict it once accepted.
    task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
                             input logic signed [SAMPLE_W-1:0] r);
        t_stereo w;
        w.left  = l;
        w.right = r;
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_left_in  <= l;
        i_right_in <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_mix.push_back(mix_model(w));
    endtask

    // Stop offering and wait until every predicted word has come out.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_mix.size() != 0) @(posedge i_clk);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_AMOUNT: amount_q = val[AMT_W-1:0];
            CFG_WIDTH:  width_q  = val[WID_W-1:0];
            CFG_DLY_L:  dly_l_q  = val[DLY_W-1:0];
            CFG_DLY_R:  dly_r_q  = val[DLY_W-1:0];
        endcase
    endtask

    task automatic write_all(input int amt, input int wid, input int dl, input int dr);
        write_reg(CFG_AMOUNT, CFG_DATA_W'(amt));
        write_reg(CFG_WIDTH, CFG_DATA_W'(wid));
        write_reg(CFG_DLY_L, CFG_DATA_W'(dl));
        write_reg(CFG_DLY_R, CFG_DATA_W'(dr));
    endtask

    // Amount at reset and at the bypass threshold: words pass through untouched.
    task automatic test_bypass();
        send_pair(PEAK_POS, PEAK_POS);
        send_pair(PEAK_NEG, PEAK_NEG);
        send_pair(PEAK_POS, PEAK_NEG);
        send_pair(SAMPLE_W'(-1), SAMPLE_W'(1));
        settle();
        write_reg(CFG_AMOUNT, CFG_DATA_W'(BYPASS_LIMIT));
        send_pair(PEAK_NEG, PEAK_POS);
        send_pair(SAMPLE_W'(0), SAMPLE_W'(-1));
        settle();
    endtask

    // Full wet gain and width with full-scale words, so the outputs clip.
    task automatic test_saturation();
        write_all(4096, 8192, 0, 1);
        send_pair(PEAK_POS, PEAK_POS);
        send_pair(PEAK_NEG, PEAK_NEG);
        send_pair(PEAK_POS, PEAK_NEG);
        send_pair(PEAK_NEG, PEAK_POS);
        send_pair(SAMPLE_W'(-1), SAMPLE_W'(0));
        settle();
    endtask

    // Registers above range, longest and zero delays, then just above bypass.
    task automatic test_reg_limits();
        write_all(8191, 16383, 8191, 0);
        send_pair(PEAK_NEG, PEAK_POS);
        send_pair(PEAK_POS, PEAK_NEG);
        send_pair(SAMPLE_W'(1), SAMPLE_W'(2));
        settle();
        write_all(41, 0, 3, 3);
        send_pair(rand_sample(), rand_sample());
        send_pair(rand_sample(), rand_sample());
        send_pair(PEAK_NEG, SAMPLE_W'(-1));
        settle();
    endtask

    // The sink holds off for a long stretch while words keep coming.
    task automatic test_backpressure();
        write_all(2048, 6000, 5, 9);
        stall_left = 400;
        for (int i = 0; i < 40; i++) send_pair(rand_sample(), rand_sample());
        settle();
    endtask

    // Random register settings per phase, random words within each phase.
    task automatic test_random_mix(input int n_phases, input int per_phase);
        int amt, wid, dl, dr;
        for (int p = 0; p < n_phases; p++) begin
            settle();
            case ($urandom_range(5))
                0: amt = $urandom_range(40);
                1: amt = 4096;
                2: amt = $urandom_range(8191, 4097);
                default: amt = $urandom_range(4096, 41);
            endcase
            case ($urandom_range(4))
                0: wid = 0;
                1: wid = 8192;
                2: wid = $urandom_range(16383, 8193);
                default: wid = $urandom_range(8192);
            endcase
            case ($urandom_range(4))
                0: dl = $urandom_range(16);
                1: dl = 8191;
                2: dl = $urandom_range(8191);
                default: dl = $urandom_range(300);
            endcase
            case ($urandom_range(4))
                0: dr = $urandom_range(16);
                1: dr = 0;
                2: dr = $urandom_range(8191);
                default: dr = $urandom_range(300);
            endcase
            write_all(amt, wid, dl, dr);
            steady = (p == 2);
            for (int i = 0; i < per_phase; i++) send_pair(rand_sample(), rand_sample());
        end
        steady = 1'b0;
    endtask

    // Output side pacing: random stalls, a forced hold-off, or always ready.
    initial begin : sink_pacing
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (steady) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compare each accepted output word with the oldest prediction.
    initial begin : out_check
        t_stereo want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_mix.size() == 0) begin
                    $error("unexpected output word: left_out %0d, right_out %0d",
                           o_left_out, o_right_out);
                    n_fail++;
                end else begin
                    want = pending_mix.pop_front();
                    if (o_left_out !== want.left) begin
                        $error("left_out: expected %0d, got %0d", want.left, o_left_out);
                        n_fail++;
                    end
                    if (o_right_out !== want.right) begin
                        $error("right_out: expected %0d, got %0d", want.right, o_right_out);
                        n_fail++;
                    end
                end
            end
        end
    end

    // Main sequence.
    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_AMOUNT;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_left_in  = '0;
        i_right_in = '0;
        foreach (mono_line[k]) mono_line[k] = '0;
        head     = 0;
        amount_q = AMOUNT_RST;
        width_q  = WIDTH_RST;
        dly_l_q  = DLY_L_RST;
        dly_r_q  = DLY_R_RST;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_bypass();
        test_saturation();
        test_reg_limits();
        test_backpressure();
        test_random_mix(8, 225);
        settle();
        repeat (16) @(posedge i_clk);

        if (n_fail == 0) begin
            $display("stereo_doubler_delay_width_top: match");
        end else begin
            $display("stereo_doubler_delay_width_top: mismatch");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/sdw_pkg.sv
rtl/sdw_ram.sv
rtl/sdw_addr.sv
rtl/sdw_dp.sv
rtl/stereo_doubler_delay_width_top.sv
tb/sv/stereo_doubler_delay_width_top_tb.sv
